// ----- design/frfe_pkg.sv -----
// ----------------------------------------------------------------------------
// frfe_pkg
// Shared types and constants of the FIR frequency response evaluator.
// ----------------------------------------------------------------------------
package frfe_pkg;

    // configuration register map
    localparam int          PADDR_W         = 3;
    localparam logic        REG_TAP_COUNT   = 1'b0;
    localparam logic [6:0]  TAP_COUNT_RESET = 7'd4;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // cordic datapath, Q2.30 with headroom
    localparam int CORDIC_STAGES = 16;
    localparam int XY_W          = 34;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN  = XY_W'(652032874);
    localparam logic signed [XY_W-1:0] QUARTER_TURN = XY_W'(1073741824);
    localparam logic signed [XY_W-1:0] HALF_TURN    = XY_W'(64'sd2147483648);
    localparam logic signed [XY_W-1:0] RND_Q15      = XY_W'(16384);

    localparam logic [31:0] ATAN_TURNS [CORDIC_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    // classified word waiting for the back end
    typedef struct packed {
        logic               is_eval;
        logic               wr_ok;
        logic [5:0]         tap_index;
        logic signed [15:0] coeff;
        logic [15:0]        freq_word;
    } t_cmd;

    // cordic pipeline output and status
    typedef struct packed {
        logic               valid;
        logic               busy;
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
        logic signed [15:0] tag;
    } t_cs_res;

endpackage

// ----- design/fir_frequency_response_eval_core.sv -----
// ----------------------------------------------------------------------------
// fir_frequency_response_eval_core
// Direct evaluation of an FIR filter's complex frequency response.
// ----------------------------------------------------------------------------
// A load word (mode 0) writes one Q1.15 coefficient. An evaluate word
// (mode 1) walks tap_count taps (capped at MAX_TAPS), issuing one tap per
// cycle into an 18-stage cordic pipeline, then one multiply and one
// accumulate stage; after the tap walk and the pipeline drain it returns
// real_sum and imag_sum in Q8.16. A four-word queue lets input words be
// accepted while an evaluation runs and a result waits to be taken.
// Coefficients must be written before an evaluation reads them; the store
// is not cleared.
// ----------------------------------------------------------------------------
module fir_frequency_response_eval_core import frfe_pkg::*; #(
    parameter int MAX_TAPS   = 64,
    parameter int PHASE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic [5:0]         i_tap_index,
    input  logic signed [15:0] i_coefficient,
    input  logic [15:0]        i_freq_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_real_sum,
    output logic signed [23:0] o_imag_sum,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [6:0]         r_tap_count;
    logic               cmd_valid;
    t_cmd               cmd;
    logic               pop;
    logic               cs_valid;
    logic [31:0]        cs_turn;
    logic signed [15:0] cs_tag;
    t_cs_res            cs_res;

    // register select is the word address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TAP_COUNT)) begin
            r_tap_count <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TAP_COUNT) ? {25'b0, r_tap_count} : 32'b0;

    frfe_front #(
        .MAX_TAPS (MAX_TAPS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_tap_index   (i_tap_index),
        .i_coefficient (i_coefficient),
        .i_freq_word   (i_freq_word),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_pop         (pop)
    );

    frfe_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cs_valid),
        .i_turn  (cs_turn),
        .i_tag   (cs_tag),
        .o_res   (cs_res)
    );

    frfe_back #(
        .MAX_TAPS   (MAX_TAPS),
        .PHASE_BITS (PHASE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tap_count (r_tap_count),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_cs_valid  (cs_valid),
        .o_cs_turn   (cs_turn),
        .o_cs_tag    (cs_tag),
        .i_cs        (cs_res),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_real_sum  (o_real_sum),
        .o_imag_sum  (o_imag_sum)
    );

endmodule

// ----- design/frfe_front.sv -----
// ----------------------------------------------------------------------------
// frfe_front
// Accepts input words, classifies them as coefficient loads or evaluations
// and holds them in a short in-order queue for the back end.
// ----------------------------------------------------------------------------
module frfe_front import frfe_pkg::*; #(
    parameter int MAX_TAPS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic [5:0]         i_tap_index,
    input  logic signed [15:0] i_coefficient,
    input  logic [15:0]        i_freq_word,
    output logic               o_cmd_valid,
    output t_cmd               o_cmd,
    input  logic               i_pop
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    t_cmd              cls;

    always_comb begin
        cls.is_eval   = i_mode;
        cls.wr_ok     = (32'(i_tap_index) < MAX_TAPS);
        cls.tap_index = i_tap_index;
        cls.coeff     = i_coefficient;
        cls.freq_word = i_freq_word;
    end

    assign o_in_stall  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

// ----- design/frfe_cordic.sv -----
// ----------------------------------------------------------------------------
// frfe_cordic
// Pipelined 16-stage rotation cordic: turns a 32-bit phase into Q1.15
// cosine and sine, carrying a coefficient alongside as a tag.
// ----------------------------------------------------------------------------
module frfe_cordic import frfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [31:0]        i_turn,
    input  logic signed [15:0] i_tag,
    output t_cs_res            o_res
);

    logic                   r_v    [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] r_x    [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] r_y    [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] r_z    [CORDIC_STAGES+1];
    logic                   r_flip [CORDIC_STAGES+1];
    logic signed [15:0]     r_tag  [CORDIC_STAGES+1];

    logic                   r_ov;
    logic signed [15:0]     r_cos;
    logic signed [15:0]     r_sin;
    logic signed [15:0]     r_otag;

    logic signed [XY_W-1:0] z_in;
    logic signed [XY_W-1:0] z_fold;
    logic                   flip;
    logic signed [XY_W-1:0] xf;
    logic signed [XY_W-1:0] yf;
    logic                   busy;

    function automatic logic signed [15:0] sat16(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] s;
        s = (v + RND_Q15) >>> 15;
        if (s > XY_W'(32767)) begin
            return 16'sh7FFF;
        end else if (s < XY_W'(-32768)) begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    // fold into [-1/4, 1/4] turn
    always_comb begin
        z_in   = XY_W'($signed(i_turn));
        z_fold = z_in;
        flip   = 1'b0;
        if (z_in > QUARTER_TURN) begin
            z_fold = z_in - HALF_TURN;
            flip   = 1'b1;
        end else if (z_in < -QUARTER_TURN) begin
            z_fold = z_in + HALF_TURN;
            flip   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= CORDIC_GAIN;
        r_y[0]    <= '0;
        r_z[0]    <= z_fold;
        r_flip[0] <= flip;
        r_tag[0]  <= i_tag;
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [XY_W-1:0] at;

        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        assign at = XY_W'($signed({1'b0, ATAN_TURNS[i]}));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!r_z[i][XY_W-1]) begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - at;
            end else begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + at;
            end
            r_flip[i+1] <= r_flip[i];
            r_tag[i+1]  <= r_tag[i];
        end
    end

    assign xf = r_flip[CORDIC_STAGES] ? -r_x[CORDIC_STAGES] : r_x[CORDIC_STAGES];
    assign yf = r_flip[CORDIC_STAGES] ? -r_y[CORDIC_STAGES] : r_y[CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos  <= sat16(xf);
        r_sin  <= sat16(yf);
        r_otag <= r_tag[CORDIC_STAGES];
    end

    always_comb begin
        busy = r_ov;
        for (int k = 0; k <= CORDIC_STAGES; k++) begin
            busy = busy | r_v[k];
        end
    end

    always_comb begin
        o_res.valid = r_ov;
        o_res.busy  = busy;
        o_res.cos_v = r_cos;
        o_res.sin_v = r_sin;
        o_res.tag   = r_otag;
    end

endmodule

// ----- design/frfe_back.sv -----
// ----------------------------------------------------------------------------
// frfe_back
// Executes queued words: writes the coefficient store, or walks the taps
// through the cordic, multiplies, accumulates and rounds one response.
// ----------------------------------------------------------------------------
module frfe_back import frfe_pkg::*; #(
    parameter int MAX_TAPS   = 64,
    parameter int PHASE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [6:0]         i_tap_count,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_cs_valid,
    output logic [31:0]        o_cs_turn,
    output logic signed [15:0] o_cs_tag,
    input  t_cs_res            i_cs,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_real_sum,
    output logic signed [23:0] o_imag_sum
);

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = 33 + AW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [CW-1:0]           r_n;
    logic [CW-1:0]           r_taps;
    logic [PHASE_BITS-1:0]   r_phase;
    logic [PHASE_BITS-1:0]   r_step;
    logic                    r_rd_v;
    logic [31:0]             r_rd_turn;
    logic signed [15:0]      r_coef;
    logic                    r_pv;
    logic signed [31:0]      r_pc;
    logic signed [31:0]      r_ps;
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;
    logic                    r_out_v;
    logic signed [23:0]      r_re;
    logic signed [23:0]      r_im;

    logic signed [15:0]      mem [MAX_TAPS];

    logic [CW-1:0]           taps_sat;
    logic [39:0]             fw_ext;
    logic [PHASE_BITS-1:0]   step;
    logic                    eval_start;
    logic                    out_load;
    logic                    drained;

    function automatic logic signed [23:0] round_sat24(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = (v + ACC_W'(8192)) >>> 14;
        if (s > ACC_W'(8388607)) begin
            return 24'sh7FFFFF;
        end else if (s < ACC_W'(-8388608)) begin
            return 24'sh800000;
        end
        return s[23:0];
    endfunction

    assign taps_sat   = (32'(i_tap_count) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(i_tap_count);
    // step = freq_word scaled to the phase width, truncating when narrower
    assign fw_ext     = {i_cmd.freq_word, 24'b0};
    assign step       = fw_ext[39 -: PHASE_BITS];
    assign o_pop      = (r_state == ST_IDLE) && i_cmd_valid;
    assign eval_start = o_pop && i_cmd.is_eval;
    assign drained    = !r_rd_v && !i_cs.busy && !r_pv;
    assign out_load   = (r_state == ST_FINAL) && (!r_out_v || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (eval_start) begin
                    n_state = (taps_sat == '0) ? ST_DRAIN : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (CW'(r_n + CW'(1)) == r_taps) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drained) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rd_v  <= 1'b0;
            r_pv    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= (r_state == ST_ISSUE);
            r_pv    <= i_cs.valid;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // tap walk: phase steps once per issued tap
    always_ff @(posedge i_clk) begin
        if (eval_start) begin
            r_taps  <= taps_sat;
            r_step  <= step;
            r_phase <= '0;
            r_n     <= '0;
        end else if (r_state == ST_ISSUE) begin
            r_phase <= r_phase + r_step;
            r_n     <= r_n + CW'(1);
        end
        r_rd_turn <= {r_phase, {(32 - PHASE_BITS){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_cmd.is_eval && i_cmd.wr_ok) begin
            mem[AW'(i_cmd.tap_index)] <= i_cmd.coeff;
        end
        if (r_state == ST_ISSUE) begin
            r_coef <= mem[r_n[AW-1:0]];
        end
    end

    assign o_cs_valid = r_rd_v;
    assign o_cs_turn  = r_rd_turn;
    assign o_cs_tag   = r_coef;

    always_ff @(posedge i_clk) begin
        r_pc <= i_cs.tag * i_cs.cos_v;
        r_ps <= i_cs.tag * i_cs.sin_v;
        if (eval_start) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_pv) begin
            r_acc_re <= r_acc_re + ACC_W'(r_pc);
            r_acc_im <= r_acc_im - ACC_W'(r_ps);
        end
        if (out_load) begin
            r_re <= round_sat24(r_acc_re);
            r_im <= round_sat24(r_acc_im);
        end
    end

    assign o_out_valid = r_out_v;
    assign o_real_sum  = r_re;
    assign o_imag_sum  = r_im;

    a_issue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> (r_n < r_taps))
        else $error("tap walk ran past the tap count");

    a_cs_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cs.valid |-> (r_state == ST_ISSUE || r_state == ST_DRAIN))
        else $error("cordic result outside an evaluation");

    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r_state == ST_FINAL && drained == 1'b0 || r_state == ST_FINAL))
        else $error("result loaded before the accumulation finished");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FIR frequency response evaluator. A queue of
// load and evaluate words feeds a clocked driver; a clocked monitor compares
// every result word with the response computed by a bit-exact CORDIC/DTFT
// model of the block. Tap count is changed over APB between phases.
// ----------------------------------------------------------------------------
module testbench;
    import frfe_pkg::*;

    localparam int   MAX_TAPS     = 64;
    localparam int   PHASE_BITS   = 16;
    localparam int   IDLE_PCT     = 16;
    localparam int   DRAIN_CYCLES = 120;
    localparam int   RAND_WORDS   = 129;
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_EVAL    = 1'b1;

    localparam logic [PADDR_W-1:0] ADDR_TAP_COUNT = {REG_TAP_COUNT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED  = 3'd4;

    localparam longint ROT_GAIN = 64'sd652032874;
    localparam longint Q_TURN   = 64'sd1073741824;
    localparam longint H_TURN   = 64'sd2147483648;
    localparam longint F_TURN   = 64'sd4294967296;
    localparam longint ANGLE_STEP [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    typedef struct {
        logic               mode;
        logic [5:0]         tap_index;
        logic signed [15:0] coefficient;
        logic [15:0]        freq_word;
    } t_word;

    typedef struct {
        logic signed [23:0] real_sum;
        logic signed [23:0] imag_sum;
    } t_response;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_mode;
    logic [5:0]         i_tap_index;
    logic signed [15:0] i_coefficient;
    logic [15:0]        i_freq_word;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [23:0] o_real_sum;
    logic signed [23:0] o_imag_sum;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    t_word              pending_words[$];
    t_response          expected_responses[$];
    logic signed [15:0] coeff_shadow [MAX_TAPS];
    bit                 written_taps [MAX_TAPS];
    logic [6:0]         tap_count_q;
    bit                 calm;
    bit                 in_taken;
    int                 mismatches;

    fir_frequency_response_eval_core #(
        .MAX_TAPS  (MAX_TAPS),
        .PHASE_BITS(PHASE_BITS)
    ) i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // cosine and sine of a 32-bit turn, Q1.15
    function automatic void rotate_turn(input logic [31:0] turn, output longint c,
                                        output longint s);
        longint z, x, y, dx, dy;
        bit     flip;
        z    = longint'({32'b0, turn});
        x    = ROT_GAIN;
        y    = 0;
        flip = 1'b0;
        if (z >= H_TURN)
            z -= F_TURN;
        if (z > Q_TURN) begin
            z -= H_TURN;
            flip = 1'b1;
        end else if (z < -Q_TURN) begin
            z += H_TURN;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ANGLE_STEP[i];
            end else begin
                x += dx;
                y -= dy;
                z += ANGLE_STEP[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clamp((x + 64'sd16384) >>> 15, -32768, 32767);
        s = clamp((y + 64'sd16384) >>> 15, -32768, 32767);
    endfunction

    function automatic t_response freq_response(input logic [15:0] freq_word);
        t_response             r;
        logic [PHASE_BITS-1:0] phase;
        logic [PHASE_BITS-1:0] step;
        longint                re, im, c, s, h;
        int                    taps;
        step  = freq_word;
        phase = '0;
        re    = 0;
        im    = 0;
        taps  = (tap_count_q > MAX_TAPS) ? MAX_TAPS : int'(tap_count_q);
        for (int n = 0; n < taps; n++) begin
            h = longint'(coeff_shadow[n]);
            rotate_turn({phase, {(32-PHASE_BITS){1'b0}}}, c, s);
            re += h * c;
            im -= h * s;
            phase = phase + step;
        end
        r.real_sum = 24'(clamp((re + 64'sd8192) >>> 14, -8388608, 8388607));
        r.imag_sum = 24'(clamp((im + 64'sd8192) >>> 14, -8388608, 8388607));
        return r;
    endfunction

    task automatic apply_word(input logic mode, input logic [5:0] idx,
                              input logic signed [15:0] coeff, input logic [15:0] fw);
        if (mode == MODE_LOAD)
            coeff_shadow[idx] = coeff;
        else
            expected_responses.push_back(freq_response(fw));
    endtask

    // driver: words change on the falling edge
    always @(negedge i_clk) begin
        t_word w;
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_words.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                w = pending_words.pop_front();
                i_in_valid    <= 1'b1;
                i_mode        <= w.mode;
                i_tap_index   <= w.tap_index;
                i_coefficient <= w.coefficient;
                i_freq_word   <= w.freq_word;
            end else begin
                i_in_valid    <= 1'b0;
                i_mode        <= 1'($urandom);
                i_tap_index   <= 6'($urandom);
                i_coefficient <= 16'($urandom);
                i_freq_word   <= 16'($urandom);
            end
        end
    end

    // acceptance, prediction and result checking on the rising edge
    always @(posedge i_clk) begin
        t_response e;
        in_taken <= i_rst_n && i_in_valid && (o_in_stall === 1'b0);
        if (i_rst_n && i_in_valid && o_in_stall === 1'b0)
            apply_word(i_mode, i_tap_index, i_coefficient, i_freq_word);
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_responses.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                e = expected_responses.pop_front();
                if (o_real_sum !== e.real_sum)
                    report_mismatch($sformatf("real_sum %0d, expected %0d",
                                              o_real_sum, e.real_sum));
                if (o_imag_sum !== e.imag_sum)
                    report_mismatch($sformatf("imag_sum %0d, expected %0d",
                                              o_imag_sum, e.imag_sum));
            end
        end
    end

    task automatic push_word(input logic mode, input logic [5:0] idx,
                             input logic signed [15:0] coeff, input logic [15:0] fw);
        t_word w;
        w.mode        = mode;
        w.tap_index   = idx;
        w.coefficient = coeff;
        w.freq_word   = fw;
        if (mode == MODE_LOAD)
            written_taps[idx] = 1'b1;
        pending_words.push_back(w);
    endtask

    function automatic logic [15:0] pick_value(input logic [15:0] a, input logic [15:0] b);
        case ($urandom_range(9))
            0:       return a;
            1:       return b;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_random_word();
        logic mode;
        mode = ($urandom_range(99) < 55) ? MODE_EVAL : MODE_LOAD;
        push_word(mode, 6'($urandom_range(MAX_TAPS - 1)),
                  pick_value(16'h7FFF, 16'h8000), pick_value(16'h8000, 16'h4000));
    endtask

    // let every accepted word finish, then let trailing loads settle
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_responses.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwdata  <= 32'($urandom);
    endtask

    task automatic check_tap_count_reg();
        logic [31:0] rd;
        apb_access(1'b0, ADDR_TAP_COUNT, 32'd0, rd);
        if (rd[6:0] !== tap_count_q)
            report_mismatch($sformatf("tap_count reads %0d, expected %0d", rd[6:0], tap_count_q));
    endtask

    task automatic set_tap_count(input logic [6:0] taps);
        logic [31:0] rd;
        apb_access(1'b1, ADDR_TAP_COUNT, {25'($urandom), taps}, rd);
        tap_count_q = taps;
        check_tap_count_reg();
    endtask

    initial begin
        int          plan [13] = '{1, 64, 0, 127, 17, 2, 64, 33, 9, 100, 5, 64, 3};
        int          limit;
        logic [31:0] rd;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_LOAD;
        i_tap_index   = '0;
        i_coefficient = '0;
        i_freq_word   = '0;
        i_out_stall   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 1'b0;
        in_taken      = 1'b0;
        mismatches    = 0;
        tap_count_q   = TAP_COUNT_RESET;
        for (int n = 0; n < MAX_TAPS; n++) begin
            coeff_shadow[n] = '0;
            written_taps[n] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        check_tap_count_reg();

        // directed: coefficient extremes, quarter turns, wrap, ignored fields
        push_word(MODE_LOAD, 6'd0, 16'sh7FFF, 16'h0000);
        push_word(MODE_LOAD, 6'd1, 16'sh8000, 16'hFFFF);
        push_word(MODE_LOAD, 6'd2, 16'sh0001, 16'h1234);
        push_word(MODE_LOAD, 6'd3, 16'shFFFF, 16'h8000);
        push_word(MODE_EVAL, 6'd0, 16'sh0000, 16'h0000);
        push_word(MODE_EVAL, 6'd63, 16'shFFFF, 16'h4000);
        push_word(MODE_EVAL, 6'd21, 16'sh5555, 16'h8000);
        push_word(MODE_EVAL, 6'd42, 16'shAAAA, 16'hC000);
        push_word(MODE_EVAL, 6'd0, 16'sh7FFF, 16'hFFFF);
        push_word(MODE_EVAL, 6'd1, 16'sh8000, 16'h0001);
        push_word(MODE_EVAL, 6'd5, 16'sh1234, 16'h2AAA);
        push_word(MODE_LOAD, 6'd2, 16'sh0000, 16'h7FFF);
        push_word(MODE_EVAL, 6'd0, 16'sh0000, 16'h1000);
        push_word(MODE_LOAD, 6'd63, 16'sh5A5A, 16'h0000);
        push_word(MODE_EVAL, 6'd63, 16'shFFFF, 16'h6000);
        push_word(MODE_LOAD, 6'd1, 16'sh7FFF, 16'hFFFF);
        push_word(MODE_EVAL, 6'd0, 16'sh0000, 16'hE000);
        wait_drained();

        foreach (plan[p]) begin
            // writes to an unmapped register must not disturb tap_count
            if (p % 4 == 1)
                apb_access(1'b1, ADDR_UNMAPPED, 32'($urandom), rd);
            set_tap_count(7'(plan[p]));
            calm = (p == 5);
            limit = (plan[p] > MAX_TAPS) ? MAX_TAPS : plan[p];
            for (int n = 0; n < limit; n++)
                if (!written_taps[n])
                    push_word(MODE_LOAD, 6'(n), 16'($urandom), 16'($urandom));
            repeat (RAND_WORDS) push_random_word();
            wait_drained();
        end
        calm = 1'b0;

        if (expected_responses.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_responses.size()));
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
design/frfe_pkg.sv
design/frfe_front.sv
design/frfe_cordic.sv
design/frfe_back.sv
design/fir_frequency_response_eval_core.sv
bench/testbench.sv
